FILE: design/scs_pkg.sv
// Package for the sorted code set: sizes, operation and status codes,
// the token that walks the cell chain, and the result beat layout.
// No dependencies.
package scs_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_BYTES = 6;

    localparam int KEY_W   = 48;
    localparam int IDX_W   = 4;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 3;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 5;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 6) ? {KEY_W{1'b1}} :
        KEY_W'((64'd1 << (8 * KEY_BYTES)) - 64'd1);

    localparam logic [OP_W-1:0] OP_FIND   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic             valid;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] carry;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cur;
        logic             hit;
        logic             placed;
        logic [CNT_W-1:0] pos;
    } token_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [KEY_W-1:0]   entry;
        logic [POS_W-1:0]   position;
        logic [STAT_W-1:0]  status;
    } result_t;

endpackage

FILE: design/scs_cell.sv
// One cell of the sorted code set: holds one entry and acts on the token
// passing by, then hands the token to the next cell.
// Depends on scs_pkg.
module scs_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  scs_pkg::token_t           tok_i,
    input  logic [scs_pkg::CNT_W-1:0] count_i,
    input  logic [scs_pkg::KEY_W-1:0] right_entry_i,
    output scs_pkg::token_t           tok_o,
    output logic [scs_pkg::KEY_W-1:0] entry_o
);

    scs_pkg::token_t           tok_reg;
    scs_pkg::token_t           tok_next;
    logic [scs_pkg::KEY_W-1:0] entry_reg;
    logic [scs_pkg::KEY_W-1:0] entry_next;
    logic                      in_range;
    logic                      full;

    assign in_range = tok_i.cur < count_i;
    assign full     = count_i == scs_pkg::CNT_W'(scs_pkg::CAPACITY);

    always_comb begin
        tok_next   = tok_i;
        entry_next = entry_reg;
        if (tok_i.valid) begin
            case (tok_i.op)
                scs_pkg::OP_FIND: begin
                    if (in_range && !tok_i.hit && entry_reg == tok_i.carry) begin
                        tok_next.hit = 1'b1;
                        tok_next.pos = tok_i.cur;
                    end
                end
                scs_pkg::OP_INSERT: begin
                    if (in_range) begin
                        if (!tok_i.hit && !tok_i.placed && entry_reg == tok_i.carry) begin
                            tok_next.hit = 1'b1;
                            tok_next.pos = tok_i.cur;
                        end else if (!tok_i.hit && !full && tok_i.carry < entry_reg) begin
                            entry_next     = tok_i.carry;
                            tok_next.carry = entry_reg;
                            if (!tok_i.placed) begin
                                tok_next.placed = 1'b1;
                                tok_next.pos    = tok_i.cur;
                            end
                        end
                    end else if (tok_i.cur == count_i && !tok_i.hit && !full) begin
                        entry_next = tok_i.carry;
                        if (!tok_i.placed) begin
                            tok_next.placed = 1'b1;
                            tok_next.pos    = tok_i.cur;
                        end
                    end
                end
                scs_pkg::OP_DELETE: begin
                    if (in_range) begin
                        if (!tok_i.hit && entry_reg == tok_i.carry) begin
                            tok_next.hit = 1'b1;
                            tok_next.pos = tok_i.cur;
                        end
                        if (tok_next.hit) begin
                            entry_next = right_entry_i;
                        end
                    end
                end
                scs_pkg::OP_READ: begin
                    if (in_range && (scs_pkg::CNT_W + scs_pkg::IDX_W)'(tok_i.idx) ==
                        (scs_pkg::CNT_W + scs_pkg::IDX_W)'(tok_i.cur)) begin
                        tok_next.carry = entry_reg;
                    end
                end
                default: begin
                end
            endcase
            tok_next.cur = tok_i.cur + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign tok_o   = tok_reg;
    assign entry_o = entry_reg;

endmodule

FILE: design/sorted_code_set.sv
// Top level of the sorted code set: the cell chain, the entry count and
// a two-deep result stage.
// Depends on scs_pkg and scs_cell.
//
// Keeps an ascending, duplicate-free set of up to CAPACITY codes.
// A command beat on the s_ channel carries an operation (find, insert,
// delete, clear, read), a key and an index. Each command gives exactly one
// result beat on the m_ channel with status, position, entry and count.
// A command travels as a token through a chain of CAPACITY cells, one
// cell per cycle, each cell holding one entry. Inserts and deletes shift
// entries between neighbor cells as the token passes.
// The result beat is registered in the output stage once the token leaves
// the last cell. One command is in the chain at a time, so a new command
// is taken only after the previous token leaves the last cell.
// Results wait in a two-deep output stage; a new command is taken while
// one result waits, and s_tready drops while two results wait.
// Reset empties the set and the output stage; stored codes are not cleared.
module sorted_code_set (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // operation[2:0], key[50:3], index[54:51], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // status[2:0], position[6:3], entry[54:7], count[59:55], pad
);

    localparam int N = scs_pkg::CAPACITY;

    scs_pkg::token_t           tok [N+1];
    logic [scs_pkg::KEY_W-1:0] ent [N+1];
    logic [N-1:0]              tok_valids;

    logic [scs_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      busy_reg;
    logic                      m_valid_reg, sk_valid_reg;
    scs_pkg::result_t          m_data_reg, sk_data_reg;
    scs_pkg::result_t          res;

    logic                      accept, done, pop;
    logic [scs_pkg::OP_W-1:0]  in_op;
    scs_pkg::token_t           tok_in;
    scs_pkg::token_t           res_tok;

    assign accept = s_tvalid && s_tready;
    assign in_op  = s_tdata[2:0];

    always_comb begin
        tok_in.valid  = accept;
        tok_in.op     = in_op;
        tok_in.carry  = (in_op == scs_pkg::OP_READ) ? '0 : (s_tdata[50:3] & scs_pkg::KEY_MASK);
        tok_in.idx    = s_tdata[54:51];
        tok_in.cur    = '0;
        tok_in.hit    = 1'b0;
        tok_in.placed = 1'b0;
        tok_in.pos    = '0;
    end

    assign tok[0] = tok_in;
    assign ent[N] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        scs_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .tok_i         (tok[i]),
            .count_i       (count_reg),
            .right_entry_i (ent[i+1]),
            .tok_o         (tok[i+1]),
            .entry_o       (ent[i])
        );
        assign tok_valids[i] = tok[i+1].valid;
    end

    assign res_tok = tok[N];
    assign done    = res_tok.valid;

    always_comb begin
        res        = '0;
        count_next = count_reg;
        case (res_tok.op)
            scs_pkg::OP_FIND: begin
                if (res_tok.hit) begin
                    res.position = scs_pkg::POS_W'(res_tok.pos);
                end else begin
                    res.status = scs_pkg::ST_NOT_FOUND;
                end
            end
            scs_pkg::OP_INSERT: begin
                if (res_tok.hit) begin
                    res.status   = scs_pkg::ST_PRESENT;
                    res.position = scs_pkg::POS_W'(res_tok.pos);
                end else if (count_reg == scs_pkg::CNT_W'(N)) begin
                    res.status = scs_pkg::ST_FULL;
                end else begin
                    res.position = scs_pkg::POS_W'(res_tok.pos);
                    count_next   = count_reg + 1'b1;
                end
            end
            scs_pkg::OP_DELETE: begin
                if (res_tok.hit) begin
                    res.position = scs_pkg::POS_W'(res_tok.pos);
                    count_next   = count_reg - 1'b1;
                end else begin
                    res.status = scs_pkg::ST_NOT_FOUND;
                end
            end
            scs_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            scs_pkg::OP_READ: begin
                res.position = res_tok.idx;
                if ((scs_pkg::CNT_W + scs_pkg::IDX_W)'(res_tok.idx) >=
                    (scs_pkg::CNT_W + scs_pkg::IDX_W)'(count_reg)) begin
                    res.status = scs_pkg::ST_RANGE;
                end else begin
                    res.entry = res_tok.carry;
                end
            end
            default: begin
            end
        endcase
        res.count = scs_pkg::COUNT_W'(count_next);
    end

    assign pop = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else begin
            if (done) begin
                count_reg <= count_next;
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            if (!m_valid_reg || pop) begin
                if (sk_valid_reg) begin
                    m_valid_reg  <= 1'b1;
                    sk_valid_reg <= done;
                end else begin
                    m_valid_reg <= done;
                end
            end else if (done) begin
                sk_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || pop) begin
            if (sk_valid_reg) begin
                m_data_reg  <= sk_data_reg;
                sk_data_reg <= res;
            end else begin
                m_data_reg <= res;
            end
        end else if (done) begin
            sk_data_reg <= res;
        end
    end

    assign s_tready = !busy_reg && !sk_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_data_reg};

`ifndef SYNTH
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= scs_pkg::CNT_W'(N))
        else $error("entry count exceeds capacity");

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_valids))
        else $error("more than one token in the cell chain");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> busy_reg)
        else $error("token left the chain while idle");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_valid_reg |-> m_valid_reg)
        else $error("skid result held while output stage empty");
`endif

endmodule

FILE: tb/sv/sorted_code_set_checker.sv
// Checker for the sorted code set: watches the command and result streams,
// predicts every result from its own copy of the code table and counts mismatches.
// Depends on scs_pkg.
`timescale 1ns / 100ps

module sorted_code_set_checker
    import scs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,  // operation[2:0], key[50:3], index[54:51], zero pad
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,  // status[2:0], position[6:3], entry[54:7], count[59:55], pad
    output int          fail_count,
    output int          results_due,
    output int          results_seen
);

    logic [KEY_W-1:0] codes [CAPACITY];
    int               code_count = 0;
    result_t          due_results [$];
    int               fails = 0;
    int               seen = 0;

    function automatic int search_code(input logic [KEY_W-1:0] code);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = code_count - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (codes[mid] == code)
                return mid;
            if (codes[mid] < code)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return -1;
    endfunction

    function automatic result_t apply_command(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] raw_key,
                                              input logic [IDX_W-1:0] idx);
        result_t          r;
        logic [KEY_W-1:0] code;
        int               p;
        int               i;
        r    = '0;
        code = raw_key & KEY_MASK;
        case (op)
            OP_FIND: begin
                p = search_code(code);
                if (p < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r.position = POS_W'(p);
            end
            OP_INSERT: begin
                p = search_code(code);
                if (p >= 0) begin
                    r.status   = ST_PRESENT;
                    r.position = POS_W'(p);
                end else if (code_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    i = code_count;
                    while (i > 0 && codes[i-1] > code) begin
                        codes[i] = codes[i-1];
                        i--;
                    end
                    codes[i] = code;
                    code_count++;
                    r.position = POS_W'(i);
                end
            end
            OP_DELETE: begin
                p = search_code(code);
                if (p < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (i = p; i + 1 < code_count; i++)
                        codes[i] = codes[i+1];
                    code_count--;
                    r.position = POS_W'(p);
                end
            end
            OP_CLEAR: begin
                code_count = 0;
            end
            OP_READ: begin
                r.position = idx;
                if (int'(idx) >= code_count)
                    r.status = ST_RANGE;
                else
                    r.entry = codes[idx];
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(code_count);
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            code_count = 0;
            due_results.delete();
        end else begin
            if (s_tvalid && s_tready)
                due_results.push_back(apply_command(s_tdata[2:0], s_tdata[50:3],
                                                    s_tdata[54:51]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[59:0];
                seen++;
                if (due_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result beat: status %0d position %0d entry %h count %0d",
                                 $time, got.status, got.position, got.entry, got.count);
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.position !== want.position ||
                        got.entry !== want.entry || got.count !== want.count) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: result %0d mismatch", $time, seen);
                            $display("    expected status %0d position %0d entry %h count %0d",
                                     want.status, want.position, want.entry, want.count);
                            $display("    actual   status %0d position %0d entry %h count %0d",
                                     got.status, got.position, got.entry, got.count);
                        end
                    end
                end
            end
        end
        fail_count   <= fails;
        results_due  <= due_results.size();
        results_seen <= seen;
    end

endmodule

FILE: tb/sv/sorted_code_set_test.sv
// Top of the sorted code set testbench: clock, reset, command stimulus and
// result-side backpressure, with the verdict taken from the checker.
// Depends on scs_pkg, sorted_code_set and sorted_code_set_checker.
`timescale 1ns / 100ps

module sorted_code_set_test;
    import scs_pkg::*;

    localparam logic [OP_W-1:0]  OP_FIRST_UNUSED  = 3'd5;
    localparam logic [OP_W-1:0]  OP_SECOND_UNUSED = 3'd6;
    localparam logic [OP_W-1:0]  OP_LAST_UNUSED   = 3'd7;
    localparam logic [KEY_W-1:0] KEY_ALL_ONES    = {KEY_W{1'b1}};
    localparam logic [KEY_W-1:0] KEY_ZERO        = {KEY_W{1'b0}};
    localparam int ITEM_TOTAL  = 1850;
    localparam int DIRECTED    = 24;
    localparam int CALM_ITEMS  = 200;
    localparam int SEGMENT     = 120;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;  // operation[2:0], key[50:3], index[54:51], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // status[2:0], position[6:3], entry[54:7], count[59:55], pad

    int fail_count;
    int results_due;
    int results_seen;

    bit idle_on    = 1'b1;
    bit calm       = 1'b0;
    int stall_left = 0;
    int cycles     = 0;
    int sent_by_op [8];
    logic [KEY_W-1:0] recent_keys [$];

    always #5 aclk = ~aclk;

    sorted_code_set u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_code_set_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .results_due  (results_due),
        .results_seen (results_seen)
    );

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idle_on && !calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycles, results_due);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] code,
                                input logic [IDX_W-1:0] idx);
        int gap;
        if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, idx, code, op};
        do @(posedge aclk); while (!s_tready);
        sent_by_op[op]++;
        if (op == OP_INSERT) begin
            recent_keys.push_back(code);
            if (recent_keys.size() > 24)
                void'(recent_keys.pop_front());
        end
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return ($urandom_range(0, 1) != 0) ? KEY_ALL_ONES : KEY_ZERO;
        if (roll < 45 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (roll < 65)
            return KEY_W'($urandom_range(0, 31)) << (43 * $urandom_range(0, 1));
        return KEY_W'({$urandom, $urandom});
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input mix_t mix);
        int roll;
        int w_insert;
        int w_find;
        int w_delete;
        int w_read;
        int w_clear;
        case (mix)
            MIX_FILL: begin
                w_insert = 60; w_find = 15; w_delete = 6;  w_read = 14; w_clear = 1;
            end
            MIX_CHURN: begin
                w_insert = 30; w_find = 25; w_delete = 25; w_read = 15; w_clear = 2;
            end
            default: begin
                w_insert = 10; w_find = 20; w_delete = 50; w_read = 15; w_clear = 2;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < w_insert)
            return OP_INSERT;
        roll -= w_insert;
        if (roll < w_find)
            return OP_FIND;
        roll -= w_find;
        if (roll < w_delete)
            return OP_DELETE;
        roll -= w_delete;
        if (roll < w_read)
            return OP_READ;
        roll -= w_read;
        if (roll < w_clear)
            return OP_CLEAR;
        return OP_FIRST_UNUSED + OP_W'($urandom_range(0, 2));
    endfunction

    initial begin
        int   n;
        mix_t mix;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table, both key extremes, a duplicate, reads in and out of range,
        // the unused operation codes, deletes that hit and miss, and a clear.
        send_command(OP_CLEAR,  KEY_ZERO, 4'd0);
        send_command(OP_FIND,   KEY_ZERO, 4'd15);
        send_command(OP_DELETE, KEY_ALL_ONES, 4'd0);
        send_command(OP_READ,   KEY_ZERO, 4'd0);
        send_command(OP_INSERT, KEY_ALL_ONES, 4'd0);
        send_command(OP_INSERT, KEY_ZERO, 4'd0);
        send_command(OP_INSERT, KEY_ZERO, 4'd0);
        send_command(OP_INSERT, 48'h8000_0000_0000, 4'd0);
        send_command(OP_INSERT, 48'h0000_0000_0001, 4'd0);
        send_command(OP_FIND,   KEY_ALL_ONES, 4'd0);
        send_command(OP_FIND,   48'h7FFF_FFFF_FFFF, 4'd0);
        send_command(OP_READ,   KEY_ZERO, 4'd0);
        send_command(OP_READ,   KEY_ALL_ONES, 4'd3);
        send_command(OP_READ,   KEY_ZERO, 4'd4);
        send_command(OP_READ,   KEY_ZERO, 4'd15);
        send_command(OP_FIRST_UNUSED,  KEY_ALL_ONES, 4'd15);
        send_command(OP_SECOND_UNUSED, 48'h5555_5555_5555, 4'd5);
        send_command(OP_LAST_UNUSED,   48'hAAAA_AAAA_AAAA, 4'd10);
        send_command(OP_DELETE, KEY_ZERO, 4'd0);
        send_command(OP_DELETE, KEY_ZERO, 4'd0);
        send_command(OP_INSERT, 48'h5555_5555_5555, 4'd0);
        send_command(OP_INSERT, 48'hAAAA_AAAA_AAAA, 4'd0);
        send_command(OP_CLEAR,  KEY_ALL_ONES, 4'd7);
        send_command(OP_READ,   KEY_ZERO, 4'd0);

        mix = MIX_FILL;
        for (n = 0; n < ITEM_TOTAL - DIRECTED; n++) begin
            if (n % SEGMENT == 0 && n != 0) begin
                mix = mix_t'($urandom_range(0, 2));
                idle_on <= ($urandom_range(0, 3) != 0);
            end
            if (n == ITEM_TOTAL - DIRECTED - CALM_ITEMS)
                calm <= 1'b1;
            send_command(pick_op(mix), pick_key(), IDX_W'($urandom_range(0, 15)));
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (results_due != 0);
        repeat (CAPACITY + 4) @(posedge aclk);

        $display("Sent %0d commands: %0d find, %0d insert, %0d delete, %0d clear, %0d read,",
                 ITEM_TOTAL, sent_by_op[OP_FIND], sent_by_op[OP_INSERT],
                 sent_by_op[OP_DELETE], sent_by_op[OP_CLEAR], sent_by_op[OP_READ]);
        $display("    %0d unused; compared %0d result beats, %0d mismatches",
                 sent_by_op[OP_FIRST_UNUSED] + sent_by_op[OP_SECOND_UNUSED] +
                 sent_by_op[OP_LAST_UNUSED], results_seen, fail_count);
        if (fail_count == 0 && results_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sorted_code_set.f
design/scs_pkg.sv
design/scs_cell.sv
design/sorted_code_set.sv
tb/sv/sorted_code_set_checker.sv
tb/sv/sorted_code_set_test.sv
